/* hw/rtl/sdepq_pkg.sv */
`default_nettype none

package sdepq_pkg;

    localparam int IdWidth   = 16;
    localparam int PrioWidth = 8;
    localparam int FillWidth = 5;

    localparam logic [1:0] FUNC_INSERT    = 2'd0;
    localparam logic [1:0] FUNC_POP_LOW   = 2'd1;
    localparam logic [1:0] FUNC_POP_HIGH  = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic [IdWidth-1:0]   id;
        logic [PrioWidth-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic                 insert;
        logic                 pop_low;
        logic                 pop_high;
        logic [IdWidth-1:0]   id;
        logic [PrioWidth-1:0] prio;
    } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/sdepq_cell.sv */
`default_nettype none

module sdepq_cell
    import sdepq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cmd_t   cmd,
    input  wire entry_t prev_entry,
    input  wire logic   prev_keep,
    input  wire entry_t next_entry,
    output entry_t      entry,
    output logic        keep,
    output logic        tail
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [IdWidth-1:0]   id_reg;
    logic [IdWidth-1:0]   id_next;
    logic [PrioWidth-1:0] prio_reg;
    logic [PrioWidth-1:0] prio_next;

    assign entry = '{valid: valid_reg, id: id_reg, prio: prio_reg};
    assign keep  = valid_reg && (prio_reg <= cmd.prio);
    assign tail  = valid_reg && !next_entry.valid;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        if (cmd.insert && !keep)
        begin
            if (prev_keep)
            begin
                valid_next = 1'b1;
                id_next    = cmd.id;
                prio_next  = cmd.prio;
            end
            else
            begin
                valid_next = prev_entry.valid;
                id_next    = prev_entry.id;
                prio_next  = prev_entry.prio;
            end
        end
        else if (cmd.pop_low)
        begin
            valid_next = next_entry.valid;
            id_next    = next_entry.id;
            prio_next  = next_entry.prio;
        end
        else if (cmd.pop_high && tail)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/sorted_double_ended_priority_queue_top.sv */
// A result is registered and presented in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; every cell of the chain compares and
// shifts in the same cycle, so the rate is bounded only by output back-pressure.
// Reset: asynchronous, active low; it empties the chain and the output register.
`default_nettype none

module sorted_double_ended_priority_queue_top
    import sdepq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // func[1:0], ticket_id[17:2], prio[25:18]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // ok[0], out_id[16:1], out_prio[24:17], fill[29:25]
);

    localparam int CountWidth = $clog2(CAPACITY + 1);

    entry_t cells   [CAPACITY];
    logic   keeps   [CAPACITY];
    logic   tails   [CAPACITY];
    entry_t sel_acc [CAPACITY+1];

    cmd_t                        cmd;
    logic                        accept;
    logic [1:0]                  func;
    logic                        full;
    logic                        empty;
    logic                        ok;
    logic [IdWidth-1:0]          res_id;
    logic [PrioWidth-1:0]        res_prio;
    logic [CountWidth-1:0]       count_reg;
    logic [CountWidth-1:0]       count_next;
    logic [CountWidth+FillWidth-1:0] count_ext;
    logic                        out_valid_reg;
    logic [31:0]                 out_data_reg;
    logic [31:0]                 out_data_next;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign func          = s_axis_tdata[1:0];
    assign full          = cells[CAPACITY-1].valid;
    assign empty         = !cells[0].valid;

    assign cmd.insert   = accept && (func == FUNC_INSERT) && !full;
    assign cmd.pop_low  = accept && (func == FUNC_POP_LOW) && !empty;
    assign cmd.pop_high = accept && (func == FUNC_POP_HIGH) && !empty;
    assign cmd.id       = s_axis_tdata[17:2];
    assign cmd.prio     = s_axis_tdata[25:18];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            entry_t prev_e;
            entry_t next_e;
            logic   prev_k;

            if (g == 0)
            begin : g_first
                assign prev_e = '0;
                assign prev_k = 1'b1;
            end
            else
            begin : g_mid
                assign prev_e = cells[g-1];
                assign prev_k = keeps[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign next_e = '0;
            end
            else
            begin : g_inner
                assign next_e = cells[g+1];
            end

            sdepq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .prev_entry (prev_e),
                .prev_keep  (prev_k),
                .next_entry (next_e),
                .entry      (cells[g]),
                .keep       (keeps[g]),
                .tail       (tails[g])
            );

            assign sel_acc[g+1] = sel_acc[g] | (tails[g] ? cells[g] : '0);
        end
    endgenerate

    assign sel_acc[0] = '0;

    always_comb
    begin
        ok         = cmd.insert || cmd.pop_low || cmd.pop_high;
        res_id     = '0;
        res_prio   = '0;
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop_low)
        begin
            res_id     = cells[0].id;
            res_prio   = cells[0].prio;
            count_next = count_reg - 1'b1;
        end
        else if (cmd.pop_high)
        begin
            res_id     = sel_acc[CAPACITY].id;
            res_prio   = sel_acc[CAPACITY].prio;
            count_next = count_reg - 1'b1;
        end
        count_ext     = {{FillWidth{1'b0}}, count_next};
        out_data_next = {2'b00, count_ext[FillWidth-1:0], res_prio, res_id, ok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* test/tb.sv */
`default_nettype none

module tb;
    import sdepq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Capacity = 16;
    localparam int RandomItems = 1030;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic                 ok;
        logic [IdWidth-1:0]   id;
        logic [PrioWidth-1:0] prio;
        logic [FillWidth-1:0] fill;
    } ticket_result_t;

    class ticket_scoreboard;
        logic [IdWidth-1:0]   held_ids[Capacity];
        logic [PrioWidth-1:0] held_prios[Capacity];
        int unsigned          held_count;
        ticket_result_t       awaited_q[$];
        int unsigned          errors;

        function void note_input(logic [1:0] func, logic [IdWidth-1:0] tid,
                                 logic [PrioWidth-1:0] pr);
            ticket_result_t res;
            int unsigned pos;
            res = '0;
            if (func == FUNC_INSERT)
            begin
                if (held_count < Capacity)
                begin
                    pos = 0;
                    while (pos < held_count && held_prios[pos] <= pr)
                        pos++;
                    for (int i = held_count; i > pos; i--)
                    begin
                        held_ids[i]   = held_ids[i-1];
                        held_prios[i] = held_prios[i-1];
                    end
                    held_ids[pos]   = tid;
                    held_prios[pos] = pr;
                    held_count++;
                    res.ok = 1'b1;
                end
            end
            else if ((func == FUNC_POP_LOW || func == FUNC_POP_HIGH) && held_count != 0)
            begin
                res.ok = 1'b1;
                if (func == FUNC_POP_LOW)
                begin
                    res.id   = held_ids[0];
                    res.prio = held_prios[0];
                    for (int i = 1; i < held_count; i++)
                    begin
                        held_ids[i-1]   = held_ids[i];
                        held_prios[i-1] = held_prios[i];
                    end
                end
                else
                begin
                    res.id   = held_ids[held_count-1];
                    res.prio = held_prios[held_count-1];
                end
                held_count--;
            end
            res.fill = held_count[FillWidth-1:0];
            awaited_q.push_back(res);
        endfunction

        function void check_result(logic [31:0] data);
            ticket_result_t got;
            ticket_result_t want;
            got.ok   = data[0];
            got.id   = data[16:1];
            got.prio = data[24:17];
            got.fill = data[29:25];
            if (awaited_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction ok=%0d id=%h prio=%h fill=%0d",
                         $time, got.ok, got.id, got.prio, got.fill);
                return;
            end
            want = awaited_q.pop_front();
            if (got !== want)
            begin
                errors++;
                $display({"%0t: expected ok=%0d id=%h prio=%h fill=%0d, ",
                          "got ok=%0d id=%h prio=%h fill=%0d"},
                         $time, want.ok, want.id, want.prio, want.fill,
                         got.ok, got.id, got.prio, got.fill);
            end
        endfunction

        function int unsigned pending();
            return awaited_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    ticket_scoreboard book = new();
    int unsigned      hold_request = 0;

    sorted_double_ended_priority_queue_top #(
        .CAPACITY(Capacity)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    task automatic send_item(input logic [1:0] func, input logic [IdWidth-1:0] tid,
                             input logic [PrioWidth-1:0] pr);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, pr, tid, func};
        do
            @(posedge clk);
        while (!s_axis_tready);
        book.note_input(func, tid, pr);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        if (cycles != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (book.pending() != 0);
    endtask

    task automatic send_random(input int unsigned insert_pct, input bit narrow);
        logic [1:0]           func;
        logic [PrioWidth-1:0] pr;
        if ($urandom_range(0, 99) < 3)
            func = FUNC_NONE;
        else if ($urandom_range(0, 99) < insert_pct)
            func = FUNC_INSERT;
        else
            func = $urandom_range(0, 1) ? FUNC_POP_LOW : FUNC_POP_HIGH;
        pr = narrow ? PrioWidth'($urandom_range(0, 3)) : PrioWidth'($urandom);
        send_item(func, IdWidth'($urandom), pr);
    endtask

    task automatic run_directed();
        send_item(FUNC_POP_LOW, 16'hffff, 8'hff);
        send_item(FUNC_POP_HIGH, 16'hffff, 8'hff);
        send_item(FUNC_NONE, 16'hffff, 8'hff);
        send_item(FUNC_INSERT, 16'hffff, 8'hff);
        send_item(FUNC_INSERT, 16'h0000, 8'h00);
        send_item(FUNC_INSERT, 16'h1234, 8'h80);
        send_item(FUNC_INSERT, 16'h0001, 8'h80);
        send_item(FUNC_INSERT, 16'h0002, 8'h80);
        send_item(FUNC_INSERT, 16'haaaa, 8'hff);
        send_item(FUNC_INSERT, 16'h5555, 8'h00);
        for (int i = 0; i < 9; i++)
            send_item(FUNC_INSERT, IdWidth'(16'h0100 + i), PrioWidth'(i * 29));
        // The store is full now, so this insert is refused.
        send_item(FUNC_INSERT, 16'hbeef, 8'h07);
        send_item(FUNC_NONE, 16'h0000, 8'h00);
        send_item(FUNC_POP_HIGH, 16'h0000, 8'h00);
        send_item(FUNC_POP_LOW, 16'h0000, 8'h00);
        send_item(FUNC_POP_LOW, 16'h0000, 8'h00);
        send_item(FUNC_POP_HIGH, 16'h0000, 8'h00);
    endtask

    initial
    begin
        int unsigned m_mode;
        int unsigned mode_left;
        int unsigned hold_left;
        logic        rdy;
        m_mode    = 0;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                book.check_result(m_axis_tdata);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0)
            begin
                m_mode    = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (m_mode == 0)
                rdy = 1'b1;
            else if (m_mode == 1)
                rdy = 1'($urandom_range(0, 1));
            else
                rdy = ($urandom_range(0, 3) == 0);
            m_axis_tready <= rdy;
        end
    end

    initial
    begin
        int unsigned insert_pct;
        bit          narrow;
        int unsigned burst_left;
        int unsigned steady_until;
        insert_pct   = 50;
        narrow       = 1'b0;
        burst_left   = 0;
        steady_until = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int n = 0; n < RandomItems; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: insert_pct = 25;
                    1: insert_pct = 50;
                    2: insert_pct = 65;
                    default: insert_pct = 85;
                endcase
                narrow = ($urandom_range(0, 2) == 0);
            end
            // Hold the receiver off while the sender keeps offering transactions.
            if (n == 300)
            begin
                hold_request = 90;
                steady_until = 340;
            end
            if (n == 650)
                wait_for_results();
            send_random(insert_pct, narrow);
            if (n >= steady_until && burst_left == 0)
            begin
                pause_sender($urandom_range(0, 8));
                burst_left = $urandom_range(1, 24);
            end
            else if (burst_left != 0)
                burst_left--;
        end
        wait_for_results();
        repeat (5) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/sdepq_pkg.sv
hw/rtl/sdepq_cell.sv
hw/rtl/sorted_double_ended_priority_queue_top.sv
test/tb.sv
